>>> rtl/tsdjs_pkg.sv
package tsdjs_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int GAIN_W    = 30;
    localparam int K_W       = 11;
    localparam int OUT_W     = 40;
    localparam int TOT_W     = 41;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int HEAD_N    = MAX_ITEMS + 1;
    localparam int IN_W      = K_W + 2 * GAIN_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Sequencer states; the datapath decodes them as its operation code.
    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_LINK = 5'd2;
    localparam logic [4:0] ST_INIT = 5'd3;
    localparam logic [4:0] ST_SWRD = 5'd4;
    localparam logic [4:0] ST_SWHD = 5'd5;
    localparam logic [4:0] ST_WK   = 5'd6;
    localparam logic [4:0] ST_UP   = 5'd7;
    localparam logic [4:0] ST_UPC  = 5'd8;
    localparam logic [4:0] ST_NEXT = 5'd9;
    localparam logic [4:0] ST_POP0 = 5'd10;
    localparam logic [4:0] ST_POP1 = 5'd11;
    localparam logic [4:0] ST_DN   = 5'd12;
    localparam logic [4:0] ST_DNC  = 5'd13;
    localparam logic [4:0] ST_ADV  = 5'd14;
    localparam logic [4:0] ST_FIN  = 5'd15;

    typedef struct packed {
        logic [4:0] op;
        logic       take;
    } t_cmd;

    typedef struct packed {
        logic clr_end;
        logic store_ok;
        logic last;
        logic hd_take;
        logic nxt_ok;
        logic pos_zero;
        logic up_move;
        logic pop_ok;
        logic pop_last;
        logic dn_leaf;
        logic dn_move;
        logic sw_end;
        logic side;
        logic out_full;
    } t_sts;

endpackage

>>> rtl/tsdjs_ctrl.sv
module tsdjs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  tsdjs_pkg::t_sts i_sts,
    output tsdjs_pkg::t_cmd o_cmd,
    output logic            o_in_ready
);
    import tsdjs_pkg::*;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       w_take;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_take     = o_in_ready & i_in_valid;
    assign o_cmd.op   = r_state;
    assign o_cmd.take = w_take;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (i_sts.clr_end) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_take) begin
                    if (i_sts.store_ok) n_state = ST_LINK;
                    else if (i_in_last) n_state = ST_INIT;
                end
            end
            ST_LINK: n_state = i_sts.last ? ST_INIT : ST_IDLE;
            ST_INIT: n_state = ST_SWRD;
            ST_SWRD: n_state = ST_SWHD;
            ST_SWHD: n_state = i_sts.hd_take ? ST_WK : ST_POP0;
            ST_WK:   n_state = ST_UP;
            ST_UP:   n_state = i_sts.pos_zero ? ST_NEXT : ST_UPC;
            ST_UPC:  n_state = i_sts.up_move ? ST_UP : ST_NEXT;
            ST_NEXT: n_state = i_sts.nxt_ok ? ST_WK : ST_POP0;
            ST_POP0: n_state = i_sts.pop_ok ? ST_POP1 : ST_ADV;
            ST_POP1: n_state = i_sts.pop_last ? ST_ADV : ST_DN;
            ST_DN:   n_state = i_sts.dn_leaf ? ST_ADV : ST_DNC;
            ST_DNC:  n_state = i_sts.dn_move ? ST_DN : ST_ADV;
            ST_ADV:  n_state = (i_sts.sw_end && i_sts.side) ? ST_FIN : ST_SWRD;
            ST_FIN:  if (!i_sts.out_full) n_state = ST_IDLE;
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLR;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/tsdjs_dp.sv
module tsdjs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsdjs_pkg::t_cmd                     i_cmd,
    input  logic [tsdjs_pkg::IN_TDATA_W-1:0]    i_in_data,
    input  logic                                i_in_last,
    input  logic                                i_out_ready,
    output tsdjs_pkg::t_sts                     o_sts,
    output logic                                o_out_valid,
    output logic [tsdjs_pkg::OUT_W-1:0]         o_out_data
);
    import tsdjs_pkg::*;

    // Job store: per-side bucket lists keyed by position limit.
    logic [IDX_W:0]    m_head_f [0:HEAD_N-1];
    logic [IDX_W:0]    m_head_b [0:HEAD_N-1];
    logic [IDX_W:0]    m_next   [0:MAX_ITEMS-1];
    logic [GAIN_W-1:0] m_pen    [0:MAX_ITEMS-1];
    logic [GAIN_W-1:0] m_heap   [0:MAX_ITEMS-1];

    logic [IDX_W:0]    r_hdq_f, r_hdq_b, r_nxq;
    logic [GAIN_W-1:0] r_penq, r_hpa, r_hpb;

    logic [CNT_W-1:0]  r_count, r_key, r_clr, r_sw, r_hsize;
    logic [TOT_W-1:0]  r_total;
    logic              r_side_ld, r_last, r_side, r_out_v;
    logic [IDX_W-1:0]  r_idx, r_pos;
    logic [IDX_W:0]    r_nxt;
    logic [GAIN_W-1:0] r_val;
    logic [OUT_W-1:0]  r_out;

    logic [K_W-1:0]    w_k;
    logic [GAIN_W-1:0] w_fg, w_bg, w_pen, w_min;
    logic              w_front, w_store, w_live;
    logic [CNT_W-1:0]  w_in_key, w_sw_key, w_hd_addr;
    logic [IDX_W:0]    w_hd_q, w_link_q;
    logic [IDX_W-1:0]  w_job_addr, w_parent, w_hm1;
    logic [IDX_W+1:0]  w_c1, w_c2, w_hs_x;
    logic              w_c2_ok, w_use_b;
    logic [GAIN_W-1:0] w_child;
    logic [IDX_W-1:0]  w_cidx;
    logic              w_hp_we;
    logic [IDX_W-1:0]  w_hp_wa, w_hp_ra, w_hp_rb;
    logic [GAIN_W-1:0] w_hp_wd;

    assign w_k   = i_in_data[K_W-1:0];
    assign w_fg  = i_in_data[K_W +: GAIN_W];
    assign w_bg  = i_in_data[K_W+GAIN_W +: GAIN_W];
    assign w_front = w_fg > w_bg;
    assign w_pen = w_front ? (w_fg - w_bg) : (w_bg - w_fg);
    assign w_min = w_front ? w_bg : w_fg;
    assign w_store = (32'(r_count) < MAX_ITEMS);
    assign w_in_key = (32'(w_k) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS) : CNT_W'(w_k);

    // Front slots are swept from the top down, back slots by rising limit.
    assign w_sw_key = r_side ? r_sw : (CNT_W'(MAX_ITEMS) - r_sw);
    assign w_live   = r_side ? (r_sw < r_count) : (32'(r_sw) != MAX_ITEMS);
    assign w_hd_q   = r_side ? r_hdq_b : r_hdq_f;
    assign w_link_q = r_side_ld ? r_hdq_b : r_hdq_f;

    always_comb begin
        unique case (i_cmd.op)
            ST_IDLE: w_hd_addr = w_in_key;
            ST_LINK: w_hd_addr = r_key;
            ST_CLR:  w_hd_addr = r_clr;
            default: w_hd_addr = w_sw_key;
        endcase
    end

    assign w_job_addr = (i_cmd.op == ST_SWHD) ? w_hd_q[IDX_W-1:0] : r_nxt[IDX_W-1:0];

    assign w_parent = (r_pos - 1'b1) >> 1;
    assign w_hm1    = IDX_W'(r_hsize - 1'b1);
    assign w_c1     = {1'b0, r_pos, 1'b1};
    assign w_c2     = w_c1 + 1'b1;
    assign w_hs_x   = (IDX_W+2)'(r_hsize);
    assign w_c2_ok  = w_c2 < w_hs_x;
    assign w_use_b  = w_c2_ok && (r_hpb > r_hpa);
    assign w_child  = w_use_b ? r_hpb : r_hpa;
    assign w_cidx   = w_use_b ? w_c2[IDX_W-1:0] : w_c1[IDX_W-1:0];

    always_comb begin
        w_hp_we = 1'b0;
        w_hp_wa = r_pos;
        w_hp_wd = r_val;
        w_hp_ra = w_parent;
        w_hp_rb = w_hm1;
        unique case (i_cmd.op)
            ST_UP:   w_hp_we = (r_pos == '0);
            ST_UPC: begin
                w_hp_we = 1'b1;
                if (r_hpa < r_val) w_hp_wd = r_hpa;
            end
            ST_POP0: w_hp_ra = '0;
            ST_DN: begin
                w_hp_ra = w_c1[IDX_W-1:0];
                w_hp_rb = w_c2[IDX_W-1:0];
                w_hp_we = (w_c1 >= w_hs_x);
            end
            ST_DNC: begin
                w_hp_we = 1'b1;
                if (w_child > r_val) w_hp_wd = w_child;
            end
            default: w_hp_we = 1'b0;
        endcase
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        r_hdq_f <= m_head_f[w_hd_addr];
        r_hdq_b <= m_head_b[w_hd_addr];
        if (i_cmd.op == ST_CLR) begin
            m_head_f[w_hd_addr] <= '0;
            m_head_b[w_hd_addr] <= '0;
        end else if (i_cmd.op == ST_LINK) begin
            if (r_side_ld) m_head_b[w_hd_addr] <= {1'b1, r_idx};
            else           m_head_f[w_hd_addr] <= {1'b1, r_idx};
        end else if (i_cmd.op == ST_SWHD) begin
            if (r_side) m_head_b[w_hd_addr] <= '0;
            else        m_head_f[w_hd_addr] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nxq  <= m_next[w_job_addr];
        r_penq <= m_pen[w_job_addr];
        if (i_cmd.op == ST_LINK) m_next[r_idx] <= w_link_q;
        if (i_cmd.take && w_store) m_pen[r_count[IDX_W-1:0]] <= w_pen;
    end

    always_ff @(posedge i_clk) begin
        r_hpa <= m_heap[w_hp_ra];
        r_hpb <= m_heap[w_hp_rb];
        if (w_hp_we) m_heap[w_hp_wa] <= w_hp_wd;
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_key     <= w_in_key;
            r_side_ld <= ~w_front;
            r_idx     <= r_count[IDX_W-1:0];
            r_last    <= i_in_last;
        end
        unique case (i_cmd.op)
            ST_INIT: begin
                r_side  <= 1'b0;
                r_sw    <= '0;
                r_hsize <= '0;
            end
            ST_WK: begin
                r_val   <= r_penq;
                r_pos   <= r_hsize[IDX_W-1:0];
                r_hsize <= r_hsize + 1'b1;
                r_nxt   <= r_nxq;
            end
            ST_UPC:  if (r_hpa < r_val) r_pos <= w_parent;
            ST_POP0: if (w_live && r_hsize != '0) r_hsize <= r_hsize - 1'b1;
            ST_POP1: begin
                r_val <= r_hpb;
                r_pos <= '0;
            end
            ST_DNC:  if (w_child > r_val) r_pos <= w_cidx;
            ST_ADV: begin
                if (32'(r_sw) != MAX_ITEMS) begin
                    r_sw <= r_sw + 1'b1;
                end else begin
                    r_side  <= 1'b1;
                    r_sw    <= '0;
                    r_hsize <= '0;
                end
            end
            default: r_val <= r_val;
        endcase
        if (i_cmd.op == ST_FIN && !r_out_v) r_out <= r_total[OUT_W-1:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.op == ST_CLR) r_clr <= r_clr + 1'b1;
            if (i_cmd.take && w_store) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + TOT_W'(w_min);
            end
            // Every job popped onto a slot earns back its penalty.
            if (i_cmd.op == ST_POP1) r_total <= r_total + TOT_W'(r_hpa);
            if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            if (i_cmd.op == ST_FIN && !r_out_v) begin
                r_out_v <= 1'b1;
                r_total <= '0;
                r_count <= '0;
            end
        end
    end

    assign o_sts.clr_end  = (32'(r_clr) == MAX_ITEMS);
    assign o_sts.store_ok = w_store;
    assign o_sts.last     = r_last;
    assign o_sts.hd_take  = w_hd_q[IDX_W] & w_live;
    assign o_sts.nxt_ok   = r_nxt[IDX_W];
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.up_move  = (r_hpa < r_val);
    assign o_sts.pop_ok   = w_live && (r_hsize != '0);
    assign o_sts.pop_last = (r_hsize == '0);
    assign o_sts.dn_leaf  = (w_c1 >= w_hs_x);
    assign o_sts.dn_move  = (w_child > r_val);
    assign o_sts.sw_end   = (32'(r_sw) == MAX_ITEMS);
    assign o_sts.side     = r_side;
    assign o_sts.out_full = r_out_v;

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

>>> rtl/two_sided_deadline_job_scheduler.sv
// Channel  Direction  Ports                          Contents
// input    in         i_s_tvalid/o_s_tready          tdata, tlast = last_item
// result   out        o_m_tvalid/i_m_tready          tdata = total_score
//
// Loading stores each item, then links it into its bucket list.
// After the last item each side sweeps all MAX_ITEMS+1 buckets, and each job is
// sifted through the heap for its insert and again for its pop.
// After reset a clearing pass over all MAX_ITEMS+1 bucket heads runs before the first item.
// The result sits in an output register, so loading resumes while it waits.
module two_sided_deadline_job_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // position_limit[10:0], front_gain[40:11], back_gain[70:41], zero pad
    input  logic [tsdjs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // total_score[39:0]
    output logic [tsdjs_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import tsdjs_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [OUT_W-1:0] w_out;

    tsdjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_last  (i_s_tlast),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_s_tready)
    );

    tsdjs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_s_tdata),
        .i_in_last   (i_s_tlast),
        .i_out_ready (i_m_tready),
        .o_sts       (w_sts),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (w_out)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_out);

endmodule
